// ----- src/running_median_set_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef RUNNING_MEDIAN_SET_MACROS_SVH
`define RUNNING_MEDIAN_SET_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RMS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("running_median_set: assertion failed");
`define RMS_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("running_median_set: assertion failed during or after reset");
`else
`define RMS_ASSERT(name, prop)
`define RMS_ASSERT_RST(name, prop)
`endif

`endif

// ----- src/rms_pkg.sv -----
package rms_pkg;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned OUT_CNT_W = 7;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [OUT_CNT_W-1:0]    out_count_t;

  typedef struct packed {
    logic   valid;
    value_t value;
  } cell_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
    logic med;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_MED,
    ST_RES
  } state_e;

endpackage

// ----- src/rms_req_if.sv -----
interface rms_req_if;
  import rms_pkg::*;

  logic        valid;
  logic        ready;
  logic [0:0]  req_type;
  value_t      value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink (input valid, input req_type, input value, output ready);
endinterface

// ----- src/rms_res_if.sv -----
interface rms_res_if;
  import rms_pkg::*;

  logic        valid;
  logic        ready;
  value_t      lower_median;
  value_t      upper_median;
  out_count_t  element_count;
  logic        median_valid;
  logic        request_failed;

  modport source (
    output valid, output lower_median, output upper_median, output element_count,
    output median_valid, output request_failed, input ready
  );
  modport sink (
    input valid, input lower_median, input upper_median, input element_count,
    input median_valid, input request_failed, output ready
  );
endinterface

// ----- src/running_median_set.sv -----
// Channel  Dir  Payload                                            Beat when
// req_i    in   req_type, value                                    valid && ready
// res_o    out  lower_median, upper_median, element_count,         valid && ready
//               median_valid, request_failed
// Each request passes from its beat to the result register in four steps: a compare in
// every cell, the shift along the cell chain, the median select, and the load.
// req_i is ready only in idle, so a new request is taken only once the last result is loaded.
// A result that is not taken holds the next request in its last step until res_o frees.
// Reset clears the store and the count at once; no clearing pass is needed.
`include "running_median_set_macros.svh"

module running_median_set (
  input  logic     clk_i,
  input  logic     rst_ni,
  rms_req_if.sink   req_i,
  rms_res_if.source res_o
);
  import rms_pkg::*;

  state_e     state_q, state_d;
  cell_ctl_t  ctl;
  value_t     key_q;
  logic       type_q;
  count_t     count_q, count_d;
  logic       fail_q;
  logic       found;
  logic       full;
  logic       load_res;
  count_t     lo_cnt, hi_cnt;
  value_t     lo_med, hi_med;

  logic       res_valid_q;
  value_t     res_lo_q, res_hi_q;
  out_count_t res_cnt_q;
  logic       res_mv_q, res_fail_q;

  assign full = (count_q == count_t'(CAPACITY));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (req_i.valid) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_MED;
      ST_MED:  state_d = ST_RES;
      ST_RES:  if (load_res) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    load_res = 1'b0;
    case (state_q)
      ST_CMP: ctl.cmp = 1'b1;
      ST_UPD: begin
        ctl.ins = (type_q == REQ_INSERT) && !full;
        ctl.rem = (type_q == REQ_REMOVE) && found;
      end
      ST_MED: ctl.med = 1'b1;
      ST_RES: load_res = !res_valid_q || res_o.ready;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      key_q  <= req_i.value;
      type_q <= req_i.req_type[0];
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl.ins) begin
      count_d = count_q + count_t'(1);
    end else if (ctl.rem) begin
      count_d = count_q - count_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      fail_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (state_q == ST_UPD) begin
        fail_q <= (type_q == REQ_INSERT) ? full : !found;
      end
    end
  end

  assign lo_cnt = (count_q - count_t'(1)) >> 1;
  assign hi_cnt = count_q >> 1;

  rms_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .key_i    (key_q),
    .lo_idx_i (lo_cnt[IDX_W-1:0]),
    .hi_idx_i (hi_cnt[IDX_W-1:0]),
    .found_o  (found),
    .lo_o     (lo_med),
    .hi_o     (hi_med)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load_res) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_lo_q   <= (count_q != '0) ? lo_med : '0;
      res_hi_q   <= (count_q != '0) ? hi_med : '0;
      res_cnt_q  <= out_count_t'(count_q);
      res_mv_q   <= (count_q != '0);
      res_fail_q <= fail_q;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.lower_median   = res_lo_q;
  assign res_o.upper_median   = res_hi_q;
  assign res_o.element_count  = res_cnt_q;
  assign res_o.median_valid   = res_mv_q;
  assign res_o.request_failed = res_fail_q;

  `RMS_ASSERT(a_count_bound, count_q <= count_t'(CAPACITY))
  `RMS_ASSERT(a_count_only_in_update, state_q != ST_UPD |=> $stable(count_q))
  `RMS_ASSERT(a_full_insert_keeps, (state_q == ST_UPD && type_q == REQ_INSERT && full) |=> $stable(count_q))
  `RMS_ASSERT(a_beat_starts_compare, (req_i.valid && req_i.ready) |=> state_q == ST_CMP)

endmodule

// ----- src/rms_cell.sv -----
module rms_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rms_pkg::cell_ctl_t ctl_i,
  input  rms_pkg::value_t    key_i,
  input  rms_pkg::cell_t     left_i,
  input  logic               left_le_i,
  input  rms_pkg::cell_t     right_i,
  output rms_pkg::cell_t     cell_o,
  output logic               le_o,
  output logic               eq_o
);
  import rms_pkg::*;

  cell_t cell_q, cell_d;
  logic  le_q, lt_q, eq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      le_q <= 1'b0;
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctl_i.cmp) begin
      le_q <= cell_q.valid && (cell_q.value <= key_i);
      lt_q <= cell_q.valid && (cell_q.value < key_i);
      eq_q <= cell_q.valid && (cell_q.value == key_i);
    end
  end

  // An insert shifts every entry above the key one place up; a remove
  // pulls every entry from the first copy of the key one place down.
  always_comb begin
    cell_d = cell_q;
    if (ctl_i.ins && !le_q) begin
      if (left_le_i) begin
        cell_d.valid = 1'b1;
        cell_d.value = key_i;
      end else begin
        cell_d = left_i;
      end
    end else if (ctl_i.rem && !lt_q) begin
      cell_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;
  assign le_o   = le_q;
  assign eq_o   = eq_q;

endmodule

// ----- src/rms_chain.sv -----
`include "running_median_set_macros.svh"

module rms_chain (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rms_pkg::cell_ctl_t ctl_i,
  input  rms_pkg::value_t    key_i,
  input  rms_pkg::idx_t      lo_idx_i,
  input  rms_pkg::idx_t      hi_idx_i,
  output logic               found_o,
  output rms_pkg::value_t    lo_o,
  output rms_pkg::value_t    hi_o
);
  import rms_pkg::*;

  cell_t                cells [CAPACITY];
  logic [CAPACITY-1:0]  le;
  logic [CAPACITY-1:0]  eq;
  logic [CAPACITY-1:0]  vld;
  value_t               lo_d, hi_d, lo_q, hi_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_t left, right;
    logic  left_le;

    if (i == 0) begin : g_first
      assign left    = '0;
      assign left_le = 1'b1;
    end else begin : g_mid
      assign left    = cells[i-1];
      assign left_le = le[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cells[i+1];
    end

    rms_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl_i),
      .key_i     (key_i),
      .left_i    (left),
      .left_le_i (left_le),
      .right_i   (right),
      .cell_o    (cells[i]),
      .le_o      (le[i]),
      .eq_o      (eq[i])
    );

    assign vld[i] = cells[i].valid;
  end

  assign found_o = |eq;

  always_comb begin
    lo_d = '0;
    hi_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (idx_t'(i) == lo_idx_i) begin
        lo_d = lo_d | cells[i].value;
      end
      if (idx_t'(i) == hi_idx_i) begin
        hi_d = hi_d | cells[i].value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.med) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

  `RMS_ASSERT(a_valid_packed_low, (vld & (vld + 1'b1)) == '0)
  `RMS_ASSERT(a_eq_implies_le, (eq & ~le) == '0)
  `RMS_ASSERT(a_insert_grows, ctl_i.ins |=> $countones(vld) == $past($countones(vld)) + 1)

endmodule

// ----- tb/running_median_set_tb.sv -----
`timescale 1ns / 100ps

module running_median_set_tb;
  import rms_pkg::*;

  localparam value_t VAL_MIN = {1'b1, {63{1'b0}}};
  localparam value_t VAL_MAX = {1'b0, {63{1'b1}}};
  localparam int unsigned REQUEST_TOTAL = 1550;

  typedef struct packed {
    value_t     lower;
    value_t     upper;
    out_count_t count;
    logic       nonempty;
    logic       failed;
  } median_result_t;

  typedef struct {
    logic           rtype;
    value_t         value;
    bit             typed;
    median_result_t outcome;
  } directed_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  rms_req_if req_if ();
  rms_res_if res_if ();

  running_median_set dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  value_t         sorted_vals[CAPACITY];
  int unsigned    held;
  median_result_t awaited_medians[$];
  directed_row_t  directed_rows[$];
  int unsigned    sent_count;
  int unsigned    mismatch_count;
  bit             calm;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic median_result_t median_after(input logic rtype, input value_t v);
    median_result_t r;
    int unsigned    pos;
    bit             ok;
    pos = 0;
    ok = 1'b0;
    if (rtype == REQ_INSERT) begin
      if (held < CAPACITY) begin
        while (pos < held && sorted_vals[pos] <= v) pos++;
        for (int unsigned i = held; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
        sorted_vals[pos] = v;
        held++;
        ok = 1'b1;
      end
    end else begin
      while (pos < held && sorted_vals[pos] != v) pos++;
      if (pos < held) begin
        for (int unsigned i = pos; i + 1 < held; i++) sorted_vals[i] = sorted_vals[i+1];
        sorted_vals[held-1] = '0;
        held--;
        ok = 1'b1;
      end
    end
    r = '0;
    if (held > 0) begin
      r.lower = sorted_vals[(held-1)/2];
      r.upper = sorted_vals[held/2];
      r.nonempty = 1'b1;
    end
    r.count = out_count_t'(held);
    r.failed = !ok;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    mismatch_count++;
    $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, seen, wanted);
  endtask

  task automatic add_row(input logic rtype, input value_t v, input bit typed = 1'b0,
                         input value_t lo = '0, input value_t hi = '0, input int cnt = 0,
                         input logic nonempty = 1'b0, input logic failed = 1'b0);
    directed_row_t row;
    row.rtype = rtype;
    row.value = v;
    row.typed = typed;
    row.outcome.lower = lo;
    row.outcome.upper = hi;
    row.outcome.count = out_count_t'(cnt);
    row.outcome.nonempty = nonempty;
    row.outcome.failed = failed;
    directed_rows.push_back(row);
  endtask

  task automatic send_request(input logic rtype, input value_t v, input bit typed,
                              input median_result_t typed_result);
    median_result_t predicted;
    while (!calm && $urandom_range(0, 99) < 11) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= rtype;
    req_if.value    <= v;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = median_after(rtype, v);
    awaited_medians.push_back(typed ? typed_result : predicted);
    sent_count++;
    calm = (sent_count >= 500 && sent_count < 800);
  endtask

  initial begin
    logic        rtype;
    value_t      v;
    int unsigned episode_len;
    int unsigned insert_pct;
    int unsigned pick;
    bit          first_episode;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_INSERT;
    req_if.value    <= '0;
    held = 0;
    foreach (sorted_vals[i]) sorted_vals[i] = '0;

    add_row(REQ_REMOVE, 5, 1'b1, 0, 0, 0, 1'b0, 1'b1);
    add_row(REQ_INSERT, VAL_MAX, 1'b1, VAL_MAX, VAL_MAX, 1, 1'b1, 1'b0);
    add_row(REQ_INSERT, VAL_MIN, 1'b1, VAL_MIN, VAL_MAX, 2, 1'b1, 1'b0);
    add_row(REQ_REMOVE, 7, 1'b1, VAL_MIN, VAL_MAX, 2, 1'b1, 1'b1);
    add_row(REQ_INSERT, 0, 1'b1, 0, 0, 3, 1'b1, 1'b0);
    add_row(REQ_INSERT, 0);
    add_row(REQ_INSERT, -1);
    add_row(REQ_INSERT, 1);
    add_row(REQ_INSERT, VAL_MIN);
    add_row(REQ_INSERT, VAL_MAX);
    add_row(REQ_REMOVE, 0);
    add_row(REQ_REMOVE, VAL_MAX);
    add_row(REQ_REMOVE, VAL_MAX);
    add_row(REQ_REMOVE, -1);
    add_row(REQ_REMOVE, 1);
    add_row(REQ_REMOVE, VAL_MIN);
    add_row(REQ_REMOVE, VAL_MIN);
    add_row(REQ_REMOVE, 0, 1'b1, 0, 0, 0, 1'b0, 1'b0);
    add_row(REQ_REMOVE, 0, 1'b1, 0, 0, 0, 1'b0, 1'b1);
    add_row(REQ_INSERT, -5);
    add_row(REQ_INSERT, 5);
    add_row(REQ_INSERT, 64'sh5555_5555_5555_5555);
    add_row(REQ_INSERT, 64'shAAAA_AAAA_AAAA_AAAA);
    add_row(REQ_REMOVE, 5);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].rtype, directed_rows[i].value, directed_rows[i].typed,
                   directed_rows[i].outcome);
    end

    // The first episode is insert-heavy so that the store fills and overflows early.
    first_episode = 1'b1;
    while (sent_count < REQUEST_TOTAL) begin
      episode_len = $urandom_range(40, 120);
      case ($urandom_range(0, 2))
        0: insert_pct = 90;
        1: insert_pct = 50;
        default: insert_pct = 15;
      endcase
      if (first_episode) begin
        episode_len = 90;
        insert_pct = 97;
        first_episode = 1'b0;
      end
      repeat (episode_len) begin
        rtype = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
        pick = $urandom_range(0, 99);
        if (held > 0 && (pick < 15 || (rtype == REQ_REMOVE && $urandom_range(0, 99) < 70))) begin
          v = sorted_vals[$urandom_range(0, held - 1)];
        end else if (pick < 50) begin
          v = value_t'($urandom_range(0, 16));
          v = v - 8;
        end else if (pick < 65) begin
          case ($urandom_range(0, 5))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: v = -1;
            3: v = 0;
            4: v = VAL_MIN + 1;
            default: v = VAL_MAX - 1;
          endcase
        end else begin
          v = {$urandom, $urandom};
        end
        send_request(rtype, v, 1'b0, '0);
      end
    end
    req_if.valid <= 1'b0;

    while (awaited_medians.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("running_median_set_tb: done, clean");
    end else begin
      $display("running_median_set_tb: done, errors");
    end
    $finish;
  end

  // The result side stalls at random, and once holds off long enough to back up the input.
  initial begin
    median_result_t wanted;
    int unsigned    beats_taken;
    int unsigned    hold_left;
    beats_taken = 0;
    hold_left = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        if (awaited_medians.size() == 0) begin
          report_mismatch("beat with no request pending", 64'(res_if.element_count), '0);
        end else begin
          wanted = awaited_medians.pop_front();
          if (res_if.lower_median !== wanted.lower)
            report_mismatch("lower_median", res_if.lower_median, wanted.lower);
          if (res_if.upper_median !== wanted.upper)
            report_mismatch("upper_median", res_if.upper_median, wanted.upper);
          if (res_if.element_count !== wanted.count)
            report_mismatch("element_count", 64'(res_if.element_count), 64'(wanted.count));
          if (res_if.median_valid !== wanted.nonempty)
            report_mismatch("median_valid", 64'(res_if.median_valid), 64'(wanted.nonempty));
          if (res_if.request_failed !== wanted.failed)
            report_mismatch("request_failed", 64'(res_if.request_failed),
                            64'(wanted.failed));
        end
        beats_taken++;
        if (beats_taken == 150) hold_left = 100;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= calm || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("running_median_set_tb: done, errors");
    $finish;
  end

endmodule
